@@ rtl/core/akcr_pkg.sv @@
package akcr_pkg;

    // Field widths.
    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned PCT_W    = 15;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Averaging group. The group size is a power of two, so the average is a shift.
    localparam int unsigned GROUP_SIZE = 16;
    localparam int unsigned GROUP_LOG2 = $clog2(GROUP_SIZE);
    localparam int unsigned SUM_W      = SAMPLE_W + GROUP_LOG2;
    localparam int unsigned CNT_W      = (GROUP_LOG2 > 0) ? GROUP_LOG2 : 1;

    // Scaling: percent_q8 = floor(avg * gain * 25600 / (4095 * 4096))
    //                     = floor(floor(avg * gain * 25 / 4) / 4095).
    localparam int unsigned FULL_SCALE = 4095;
    localparam int unsigned PCT_MAX    = 25600;
    localparam int unsigned SCALE_NUM  = 25;
    localparam int unsigned PROD_W     = SAMPLE_W + GAIN_W + 1;
    localparam int unsigned POS_W      = PROD_W - 2;
    localparam int unsigned SCALED_W   = 32;
    localparam int unsigned QUOT_W     = PCT_W;
    localparam int unsigned DIV_W      = SAMPLE_W + QUOT_W;
    localparam int unsigned CLAMP_LIMIT = (PCT_MAX + 1) * FULL_SCALE;

    // Queue between front and back.
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_GAIN      = 2'd1,
        CFG_ENABLE    = 2'd2
    } cfg_index_t;

    // Configuration register set.
    typedef struct packed {
        logic [SAMPLE_W-1:0]      threshold;
        logic signed [GAIN_W-1:0] gain;
        logic                     enable;
    } akcr_cfg_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } akcr_q_status_t;

endpackage

@@ rtl/core/akcr_fifo.sv @@
module akcr_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [akcr_pkg::SAMPLE_W-1:0]  push_data,
    input  logic                           pop,
    output logic [akcr_pkg::SAMPLE_W-1:0]  pop_data,
    output akcr_pkg::akcr_q_status_t       status
);
    import akcr_pkg::*;

    logic [SAMPLE_W-1:0] entry_reg [Q_DEPTH];
    logic [Q_AW-1:0]     wr_ptr_reg;
    logic [Q_AW-1:0]     rd_ptr_reg;
    logic [Q_AW:0]       fill_reg;

    // Storage writes.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign status.full  = (fill_reg == (Q_AW + 1)'(Q_DEPTH));
    assign status.empty = (fill_reg == '0);

endmodule

@@ rtl/core/akcr_front.sv @@
module akcr_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  akcr_pkg::akcr_cfg_t            cfg,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [akcr_pkg::SAMPLE_W-1:0]  adc_sample,
    input  akcr_pkg::akcr_q_status_t       q_status,
    output logic                           push,
    output logic [akcr_pkg::SAMPLE_W-1:0]  push_data
);
    import akcr_pkg::*;

    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SAMPLE_W-1:0] last_reg, last_next;
    logic [SUM_W-1:0]    sum_full;
    logic [SAMPLE_W-1:0] avg;
    logic [SAMPLE_W-1:0] diff;
    logic                accept;
    logic                group_done;
    logic                big_change;
    logic                endpoint_hit;
    logic                report;

    // Stall while the queue has no room for a possible report.
    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    // Running sum and the average of a finished group.
    assign sum_full   = sum_reg + SUM_W'(adc_sample);
    assign avg        = sum_full[GROUP_LOG2 +: SAMPLE_W];
    assign group_done = (count_reg == CNT_W'(GROUP_SIZE - 1));

    // Change detection against the last reported average.
    assign diff         = (avg > last_reg) ? avg - last_reg : last_reg - avg;
    assign big_change   = diff > cfg.threshold;
    assign endpoint_hit = (avg == '0 || avg == SAMPLE_W'(FULL_SCALE))
                       && !(last_reg == '0 || last_reg == SAMPLE_W'(FULL_SCALE));
    assign report       = accept && group_done && cfg.enable && (big_change || endpoint_hit);

    assign push      = report;
    assign push_data = avg;

    // Next state of the accumulator.
    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        last_next  = last_reg;
        if (accept)
        begin
            if (group_done)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = sum_full;
                count_next = count_reg + 1'b1;
            end
        end
        if (report)
        begin
            last_next = avg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            last_reg  <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            last_reg  <= last_next;
        end
    end

endmodule

@@ rtl/core/akcr_back.sv @@
module akcr_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  akcr_pkg::akcr_cfg_t            cfg,
    input  akcr_pkg::akcr_q_status_t       q_status,
    output logic                           pop,
    input  logic [akcr_pkg::SAMPLE_W-1:0]  pop_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [akcr_pkg::PCT_W-1:0]     percent_q8,
    output logic [akcr_pkg::SAMPLE_W-1:0]  average_reading
);
    import akcr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_DIV,
        ST_FIX,
        ST_OUT
    } state_t;

    state_t                     state_reg;
    logic [SAMPLE_W-1:0]        avg_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [DIV_W-1:0]           dvd_reg;
    logic [QUOT_W-1:0]          est_reg;
    logic                       out_valid_reg;
    logic [PCT_W-1:0]           pct_reg;
    logic [SAMPLE_W-1:0]        avg_out_reg;

    logic signed [PROD_W-1:0]   mul_c;
    logic [SCALED_W-1:0]        scaled_c;
    logic [SCALED_W-3:0]        quarter_c;
    logic [DIV_W-1:0]           est_sum_c;
    logic [QUOT_W-1:0]          est_c;
    logic [DIV_W-1:0]           back_c;
    logic [DIV_W-1:0]           rem_c;
    logic                       fix_c;

    assign pop = (state_reg == ST_IDLE) && !q_status.empty;

    // Signed product of the average and the gain.
    assign mul_c = PROD_W'($signed({1'b0, avg_reg})) * PROD_W'(cfg.gain);

    // Times 25, then a quarter: the dividend for the divide by full scale.
    assign scaled_c  = SCALED_W'(prod_reg[POS_W-1:0]) * SCALED_W'(SCALE_NUM);
    assign quarter_c = scaled_c[SCALED_W-1:2];

    // Full scale is 4096 - 1, so x * (1 + 1/4096) / 4096 is a quotient estimate
    // that never overshoots and falls short by at most one.
    assign est_sum_c = dvd_reg + DIV_W'(dvd_reg[DIV_W-1:SAMPLE_W]);
    assign est_c     = est_sum_c[DIV_W-1:SAMPLE_W];

    // Remainder left by the estimate; a full scale still in it adds one.
    assign back_c = {est_reg, SAMPLE_W'(0)} - DIV_W'(est_reg);
    assign rem_c  = dvd_reg - back_c;
    assign fix_c  = (rem_c >= DIV_W'(FULL_SCALE));

    // Sequencer: fetch, multiply, scale and clamp, estimate, correct, deliver.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            avg_reg       <= '0;
            prod_reg      <= '0;
            dvd_reg       <= '0;
            est_reg       <= '0;
            out_valid_reg <= 1'b0;
            pct_reg       <= '0;
            avg_out_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_status.empty)
                    begin
                        avg_reg   <= pop_data;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= mul_c;
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    avg_out_reg <= avg_reg;
                    if (prod_reg <= 0)
                    begin
                        pct_reg       <= '0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end
                    else if (quarter_c >= (SCALED_W - 2)'(CLAMP_LIMIT))
                    begin
                        pct_reg       <= PCT_W'(PCT_MAX);
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end
                    else
                    begin
                        dvd_reg   <= quarter_c[DIV_W-1:0];
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    est_reg   <= est_c;
                    state_reg <= ST_FIX;
                end
                ST_FIX:
                begin
                    pct_reg       <= est_reg + PCT_W'(fix_c);
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign percent_q8      = pct_reg;
    assign average_reading = avg_out_reg;

endmodule

@@ rtl/core/averaged_knob_change_reporter_core.sv @@
// Takes one sample beat per cycle unless stalled; a group's report is queued at the edge
// taking its last sample, then fetched, multiplied, scaled, estimated and corrected (zero or
// clamped skip the last two). The back end takes a new report only after delivering the
// last, output stalls included; a two-entry queue absorbs reports, and the input stalls
// only when it is full. Reset (rst_n, asynchronous, active low) clears the sum, sample count,
// last reported average and queue, and loads threshold 20, gain 1.0 and reports enabled.
module averaged_knob_change_reporter_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [akcr_pkg::SAMPLE_W-1:0]    adc_sample,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [akcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [akcr_pkg::CFG_W-1:0]       cfg_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [akcr_pkg::PCT_W-1:0]       percent_q8,
    output logic [akcr_pkg::SAMPLE_W-1:0]    average_reading
);
    import akcr_pkg::*;

    akcr_cfg_t           cfg_reg;
    akcr_q_status_t      q_status;
    logic                push;
    logic [SAMPLE_W-1:0] push_data;
    logic                pop;
    logic [SAMPLE_W-1:0] pop_data;

    // Configuration registers; unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= SAMPLE_W'(20);
            cfg_reg.gain      <= GAIN_W'(4096);
            cfg_reg.enable    <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: cfg_reg.threshold <= cfg_data[SAMPLE_W-1:0];
                CFG_GAIN:      cfg_reg.gain      <= cfg_data[GAIN_W-1:0];
                CFG_ENABLE:    cfg_reg.enable    <= cfg_data[0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    akcr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .adc_sample (adc_sample),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    akcr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    akcr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .q_status        (q_status),
        .pop             (pop),
        .pop_data        (pop_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .percent_q8      (percent_q8),
        .average_reading (average_reading)
    );

    // The queue is never written while full nor read while empty.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("report pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("report popped from an empty queue");

    // A report never exceeds full scale, and a zero average always gives zero percent.
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (percent_q8 <= PCT_W'(PCT_MAX)))
        else $error("percent_q8 above 100 percent");

    a_zero_avg: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && average_reading == '0) |-> (percent_q8 == '0))
        else $error("nonzero percent for a zero average");

endmodule
